// ===== src/shell_command_lexer_defines.svh =====
// ----------------------------------------------------------------------------
// shell_command_lexer_defines
// Assertion macros shared by the lexer modules. Each module using them has
// clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LEXER_DEFINES_SVH
`define SHELL_COMMAND_LEXER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SLX_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define SLX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/slx_pkg.sv =====
// ----------------------------------------------------------------------------
// slx_pkg
// Codes, character constants, types and the byte classifier of the shell
// command lexer.
// ----------------------------------------------------------------------------
package slx_pkg;

	// Result piece codes
	localparam logic [2:0] PIECE_WORD_BYTE = 3'd0;
	localparam logic [2:0] PIECE_WORD_END  = 3'd1;
	localparam logic [2:0] PIECE_TOKEN     = 3'd2;
	localparam logic [2:0] PIECE_ERROR     = 3'd3;
	localparam logic [2:0] PIECE_END       = 3'd4;

	// Token kinds
	localparam logic [3:0] KIND_WORD      = 4'd0;
	localparam logic [3:0] KIND_IN        = 4'd1;
	localparam logic [3:0] KIND_OUT       = 4'd2;
	localparam logic [3:0] KIND_AND       = 4'd3;
	localparam logic [3:0] KIND_OR        = 4'd4;
	localparam logic [3:0] KIND_PIPE      = 4'd5;
	localparam logic [3:0] KIND_NEWLINE   = 4'd6;
	localparam logic [3:0] KIND_SEQ       = 4'd7;
	localparam logic [3:0] KIND_BACKSLASH = 4'd8;
	localparam logic [3:0] KIND_LB        = 4'd9;
	localparam logic [3:0] KIND_RB        = 4'd10;

	// Characters
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_PIPE    = 8'h7C;
	localparam logic [7:0] CH_DIGIT_LO = 8'd48;
	localparam logic [7:0] CH_DIGIT_HI = 8'd57;
	localparam logic [7:0] CH_UPPER_LO = 8'd65;
	localparam logic [7:0] CH_UPPER_HI = 8'd90;
	localparam logic [7:0] CH_LOWER_LO = 8'd97;
	localparam logic [7:0] CH_LOWER_HI = 8'd122;

	// Result slots of one queue entry, in delivery order
	localparam int SLOT_COUNT = 6;
	localparam logic [2:0] SLOT_HELD_CLOSE = 3'd0;
	localparam logic [2:0] SLOT_HELD_RES   = 3'd1;
	localparam logic [2:0] SLOT_LAST_CLOSE = 3'd2;
	localparam logic [2:0] SLOT_LAST_RES   = 3'd3;
	localparam logic [2:0] SLOT_FIN_CLOSE  = 3'd4;
	localparam logic [2:0] SLOT_END        = 3'd5;

	// Lexer mode bits
	typedef struct packed {
		logic in_comment;
		logic cont_pending;
		logic in_word;
		logic failed;
	} lex_state_t;

	// Outcome of judging one byte
	typedef struct packed {
		logic       close_word;
		logic       res_valid;
		logic [2:0] piece;
		logic [3:0] kind;
		logic [7:0] byte_val;
		logic       pair;
		logic       line_end;
		lex_state_t st;
	} judge_t;

	// One queue entry: up to six results caused by one item
	typedef struct packed {
		logic [SLOT_COUNT-1:0] mask;
		logic [2:0]  held_piece;
		logic [3:0]  held_kind;
		logic [7:0]  held_byte;
		logic [2:0]  last_piece;
		logic [3:0]  last_kind;
		logic [7:0]  last_byte;
		logic [15:0] line_held;
		logic [15:0] line_last;
		logic [15:0] line_fin;
	} lex_entry_t;

	// Letters, digits and the punctuation allowed in words
	function automatic logic is_regular(input logic [7:0] c);
		logic punct;
		case (c) inside
			CH_BANG, CH_PERCENT, CH_PLUS, CH_COMMA, CH_MINUS, CH_DOT,
			CH_SLASH, CH_COLON, CH_AT, CH_CARET, CH_UNDER: punct = 1'b1;
			default: punct = 1'b0;
		endcase
		return punct
			|| (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI)
			|| (c >= CH_UPPER_LO && c <= CH_UPPER_HI)
			|| (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
	endfunction

	// Judge one byte with an optional look-ahead byte
	function automatic judge_t judge(input logic [7:0] ch, input logic has_next,
			input logic [7:0] nx, input lex_state_t st);
		judge_t     j;
		logic       nx_reg;
		logic       nx_lf;
		logic       nx_pipe;
		logic       nx_amp;
		logic       is_tok;
		logic       do_fail;
		logic [3:0] tok_kind;
		j        = '0;
		j.st     = st;
		nx_reg   = has_next && is_regular(nx);
		nx_lf    = has_next && (nx == CH_LF);
		nx_pipe  = has_next && (nx == CH_PIPE);
		nx_amp   = has_next && (nx == CH_AMP);
		is_tok   = 1'b0;
		do_fail  = 1'b0;
		tok_kind = KIND_WORD;
		// inside a comment only a newline matters
		if (!(st.in_comment && ch != CH_LF)) begin
			unique case (ch) inside
				CH_HASH: begin
					if (nx_reg) begin
						j.res_valid  = 1'b1;
						j.piece      = PIECE_WORD_BYTE;
						j.byte_val   = ch;
						j.st.in_word = 1'b1;
					end else begin
						j.st.in_comment = 1'b1;
					end
				end
				CH_BSLASH: begin
					j.st.cont_pending = 1'b1;
					do_fail = !nx_lf;
				end
				CH_LF: begin
					is_tok   = 1'b1;
					tok_kind = st.cont_pending ? KIND_BACKSLASH : KIND_NEWLINE;
					j.st.cont_pending = 1'b0;
					j.st.in_comment   = 1'b0;
					j.line_end        = 1'b1;
				end
				CH_SPACE, CH_TAB: begin
					j.close_word = st.in_word;
					j.st.in_word = 1'b0;
				end
				CH_SEMI: begin
					is_tok   = 1'b1;
					tok_kind = KIND_SEQ;
				end
				CH_GT: begin
					is_tok   = 1'b1;
					tok_kind = KIND_OUT;
				end
				CH_LT: begin
					is_tok   = 1'b1;
					tok_kind = KIND_IN;
				end
				CH_LPAREN: begin
					is_tok   = 1'b1;
					tok_kind = KIND_LB;
				end
				CH_RPAREN: begin
					is_tok   = 1'b1;
					tok_kind = KIND_RB;
				end
				CH_PIPE: begin
					is_tok   = 1'b1;
					tok_kind = nx_pipe ? KIND_OR : KIND_PIPE;
					j.pair   = nx_pipe;
				end
				CH_AMP: begin
					is_tok   = nx_amp;
					tok_kind = KIND_AND;
					j.pair   = nx_amp;
					do_fail  = !nx_amp;
				end
				default: begin
					if (is_regular(ch)) begin
						j.res_valid  = 1'b1;
						j.piece      = PIECE_WORD_BYTE;
						j.byte_val   = ch;
						j.st.in_word = 1'b1;
					end else begin
						do_fail = 1'b1;
					end
				end
			endcase
			// a token closes an open word first
			if (is_tok) begin
				j.close_word = st.in_word;
				j.st.in_word = 1'b0;
				j.res_valid  = 1'b1;
				j.piece      = PIECE_TOKEN;
				j.kind       = tok_kind;
			end
			// errors leave an open word as is
			if (do_fail) begin
				j.res_valid = 1'b1;
				j.piece     = PIECE_ERROR;
				j.st.failed = 1'b1;
			end
		end
		return j;
	endfunction

endpackage

// ===== src/slx_front.sv =====
// ----------------------------------------------------------------------------
// slx_front
// Accepts text bytes, holds one back for look-ahead, judges them and pushes
// one queue entry per item that causes results.
// ----------------------------------------------------------------------------
module slx_front #(
	parameter int LINE_COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_char,
	input  logic                in_last,
	input  logic                q_full,
	output logic                q_push,
	output slx_pkg::lex_entry_t q_entry
);
	import slx_pkg::*;

	localparam int LB = LINE_COUNT_BITS;

	logic [7:0]    held_byte_q;
	logic          held_valid_q;
	logic          skip_q;
	lex_state_t    st_q;
	logic [LB-1:0] line_q;

	logic          accept;
	logic          run;
	logic          run2;
	logic          j1_en;
	logic          j2_en;
	logic          skip1;
	logic          fin_close;
	judge_t        j1;
	judge_t        j2;
	lex_state_t    st1;
	lex_state_t    st2;
	logic [LB-1:0] line1;
	logic [LB-1:0] line2;

	// Saturating line increment
	function automatic logic [LB-1:0] line_inc(input logic [LB-1:0] l);
		return (&l) ? l : l + LB'(1);
	endfunction

	// Line number as shown on results, capped at 16 bits
	function automatic logic [15:0] line_show(input logic [LB-1:0] l);
		logic [31:0] w;
		w = 32'(l);
		return (w > 32'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Held byte judged against the incoming byte
	assign run   = !st_q.failed;
	assign j1_en = run && held_valid_q && !skip_q;
	assign j1    = judge(held_byte_q, 1'b1, in_char, st_q);
	assign st1   = j1_en ? j1.st : st_q;
	assign line1 = (j1_en && j1.line_end) ? line_inc(line_q) : line_q;
	assign skip1 = (run && held_valid_q) ? (j1_en && j1.pair) : skip_q;

	// Final byte judged with no look-ahead
	assign run2  = run && !st1.failed;
	assign j2_en = run2 && in_last && !skip1;
	assign j2    = judge(in_char, 1'b0, 8'h00, st1);
	assign st2   = j2_en ? j2.st : st1;
	assign line2 = (j2_en && j2.line_end) ? line_inc(line1) : line1;
	assign fin_close = run2 && in_last && !st2.failed && st2.in_word;

	// Entry assembly
	always_comb begin
		q_entry = '0;
		q_entry.mask[SLOT_HELD_CLOSE] = j1_en && j1.close_word;
		q_entry.mask[SLOT_HELD_RES]   = j1_en && j1.res_valid;
		q_entry.mask[SLOT_LAST_CLOSE] = j2_en && j2.close_word;
		q_entry.mask[SLOT_LAST_RES]   = j2_en && j2.res_valid;
		q_entry.mask[SLOT_FIN_CLOSE]  = fin_close;
		q_entry.mask[SLOT_END]        = in_last;
		q_entry.held_piece = j1.piece;
		q_entry.held_kind  = j1.kind;
		q_entry.held_byte  = j1.byte_val;
		q_entry.last_piece = j2.piece;
		q_entry.last_kind  = j2.kind;
		q_entry.last_byte  = j2.byte_val;
		q_entry.line_held  = line_show(line_q);
		q_entry.line_last  = line_show(line1);
		q_entry.line_fin   = line_show(line2);
	end

	assign q_push = accept && (|q_entry.mask);

	// Lexer state; end of text returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			skip_q       <= 1'b0;
			st_q         <= '0;
			line_q       <= LB'(1);
		end else if (accept) begin
			if (in_last) begin
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
				skip_q       <= 1'b0;
				st_q         <= '0;
				line_q       <= LB'(1);
			end else if (run) begin
				held_byte_q  <= in_char;
				held_valid_q <= run2;
				skip_q       <= skip1;
				st_q         <= st1;
				line_q       <= line1;
			end
		end
	end

endmodule

// ===== src/slx_queue.sv =====
// ----------------------------------------------------------------------------
// slx_queue
// Small first-in first-out queue of entries between front and back.
// ----------------------------------------------------------------------------
`include "shell_command_lexer_defines.svh"

module slx_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`SLX_ASSERT_HOLDS(a_count_range, 1'b1, count_q <= CW'(DEPTH), "queue count beyond depth")
	`SLX_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + CW'(1), "push lost")
	`SLX_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_q == $past(count_q) - CW'(1), "pop lost")

endmodule

// ===== src/slx_back.sv =====
// ----------------------------------------------------------------------------
// slx_back
// Takes queue entries apart into result items, one per cycle unless the
// output stalls, into an output register.
// ----------------------------------------------------------------------------
`include "shell_command_lexer_defines.svh"

module slx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  slx_pkg::lex_entry_t head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          out_piece,
	output logic [3:0]          out_kind,
	output logic [7:0]          out_byte,
	output logic [15:0]         out_line,
	output logic                out_last
);
	import slx_pkg::*;

	logic [SLOT_COUNT-1:0] rem_q;
	logic                  started_q;
	logic                  out_valid_q;
	logic [2:0]            out_piece_q;
	logic [3:0]            out_kind_q;
	logic [7:0]            out_byte_q;
	logic [15:0]           out_line_q;
	logic                  out_last_q;

	logic [SLOT_COUNT-1:0] mask;
	logic [SLOT_COUNT-1:0] pick;
	logic [SLOT_COUNT-1:0] rest;
	logic [2:0]            idx;
	logic                  load;
	logic [2:0]            sel_piece;
	logic [3:0]            sel_kind;
	logic [7:0]            sel_byte;
	logic [15:0]           sel_line;

	// Slots still owed for the head entry
	assign mask = started_q ? rem_q : head.mask;
	assign pick = mask & (~mask + SLOT_COUNT'(1));
	assign rest = mask & ~pick;
	assign load = !q_empty && (!out_valid_q || out_ready);
	assign q_pop = load && (rest == '0);

	// Lowest pending slot
	always_comb begin
		idx = SLOT_HELD_CLOSE;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = 3'(i);
			end
		end
	end

	// Field selection for the chosen slot
	always_comb begin
		sel_piece = PIECE_WORD_END;
		sel_kind  = KIND_WORD;
		sel_byte  = '0;
		sel_line  = head.line_fin;
		unique case (idx)
			SLOT_HELD_CLOSE: sel_line = head.line_held;
			SLOT_HELD_RES: begin
				sel_piece = head.held_piece;
				sel_kind  = head.held_kind;
				sel_byte  = head.held_byte;
				sel_line  = head.line_held;
			end
			SLOT_LAST_CLOSE: sel_line = head.line_last;
			SLOT_LAST_RES: begin
				sel_piece = head.last_piece;
				sel_kind  = head.last_kind;
				sel_byte  = head.last_byte;
				sel_line  = head.line_last;
			end
			SLOT_FIN_CLOSE: sel_line = head.line_fin;
			SLOT_END:       sel_piece = PIECE_END;
			default:        sel_piece = PIECE_WORD_END;
		endcase
	end

	// Progress through the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			started_q <= 1'b0;
		end else if (load) begin
			rem_q     <= rest;
			started_q <= (rest != '0);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_piece_q <= sel_piece;
			out_kind_q  <= sel_kind;
			out_byte_q  <= sel_byte;
			out_line_q  <= sel_line;
			out_last_q  <= (rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_piece = out_piece_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_line  = out_line_q;
	assign out_last  = out_last_q;

	`SLX_ASSERT_HOLDS(a_pick_onehot, !q_empty, $onehot(pick), "queue entry with no result")
	`SLX_ASSERT_HOLDS(a_started_head, started_q, !q_empty, "partial entry without queue head")
	`SLX_ASSERT_HOLDS(a_started_rem, started_q, rem_q != '0, "partial entry with nothing left")

endmodule

// ===== src/shell_command_lexer.sv =====
// ----------------------------------------------------------------------------
// shell_command_lexer
// Splits shell command text into word pieces, operator tokens and errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: one text byte per item in tdata, tlast on the final
//   byte of a text. Output channel m_axis: one result per item; tuser gives
//   piece and kind, tdata the word byte and line number, tlast marks the
//   final result caused by one input item.
//   A byte is judged when the next byte arrives (one byte of look-ahead), so
//   its results come out with the following item; the final byte of a text
//   is judged at once. An accepted item's entry is written into the queue
//   and, once it reaches the queue head, loads the output register.
//   Throughput: one input item per cycle while each item causes at most one
//   result; an item causing more results holds the output until all are taken,
//   smoothed by a QUEUE_DEPTH-entry queue between classifier and output
//   sequencer. An output stall backs up into that queue and then drops
//   s_axis_tready.
//   Reset clears all lexer state to the start of a text at line 1; the
//   output register and queue come up empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module shell_command_lexer #(
	parameter int LINE_COUNT_BITS = 16,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] byte_out, [23:8] line_number
	output logic [6:0]  m_axis_tuser,   // [2:0] piece, [6:3] kind
	output logic        m_axis_tlast
);
	import slx_pkg::*;

	logic        q_full;
	logic        q_push;
	logic        q_empty;
	logic        q_pop;
	lex_entry_t  q_in;
	lex_entry_t  q_head;
	logic [2:0]  out_piece;
	logic [3:0]  out_kind;
	logic [7:0]  out_byte;
	logic [15:0] out_line;

	// Classifier
	slx_front #(
		.LINE_COUNT_BITS(LINE_COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_in)
	);

	// Entry queue
	slx_queue #(
		.WIDTH($bits(lex_entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	// Output sequencer
	slx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_piece (out_piece),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_line  (out_line),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {out_line, out_byte};
	assign m_axis_tuser = {out_kind, out_piece};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of shell_command_lexer. A driver feeds command texts byte by byte
// from a queue filled at start: a short directed set, then random texts
// built mostly from words, operators, blanks, comments and continuations,
// with some noise. A monitor runs a lexer model on each accepted byte and
// checks every result against the oldest expected one. Both sides idle at
// random.
// ----------------------------------------------------------------------------
module tb;
	import slx_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 180;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0] ch;
		logic       last;
		int         gap;
		bit         quiet;
	} text_byte_t;

	typedef struct {
		logic [2:0]  piece;
		logic [3:0]  kind;
		logic [7:0]  chr;
		logic [15:0] line;
		logic        last;
	} lex_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] char_in
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [7:0] byte_out, [23:8] line_number
	logic [6:0]  m_axis_tuser;        // [2:0] piece, [6:3] kind
	logic        m_axis_tlast;

	text_byte_t  text_q[$];
	lex_result_t lexeme_q[$];
	text_byte_t  drv_item;
	lex_result_t want;
	bit          drv_valid;
	bit          in_fired = 1'b0;
	bit          rx_calm = 1'b0;
	bit          rx_ready;
	int          gap_left = 0;
	int          stall_left = 0;
	int          cycle_count = 0;
	int          err_count = 0;

	// Lexer model state
	logic [7:0]  lx_held;
	logic        lx_held_v;
	logic        lx_skip;
	logic        lx_comment;
	logic        lx_cont;
	logic        lx_word;
	logic [15:0] lx_line;
	logic        lx_failed;

	shell_command_lexer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Clock and reset
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------------
	// Lexer model
	// ------------------------------------------------------------------------
	function automatic void lex_clear();
		lx_held    = '0;
		lx_held_v  = 1'b0;
		lx_skip    = 1'b0;
		lx_comment = 1'b0;
		lx_cont    = 1'b0;
		lx_word    = 1'b0;
		lx_line    = 16'd1;
		lx_failed  = 1'b0;
	endfunction

	function automatic bit word_char(input logic [7:0] c);
		if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) return 1'b1;
		if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) return 1'b1;
		if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) return 1'b1;
		case (c)
			CH_BANG, CH_PERCENT, CH_PLUS, CH_COMMA, CH_MINUS, CH_DOT,
			CH_SLASH, CH_COLON, CH_AT, CH_CARET, CH_UNDER: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void lex_emit(input logic [2:0] piece, input logic [3:0] kind,
			input logic [7:0] chr);
		lex_result_t r;
		r.piece = piece;
		r.kind  = kind;
		r.chr   = chr;
		r.line  = lx_line;
		r.last  = 1'b0;
		lexeme_q.push_back(r);
	endfunction

	function automatic void lex_close_word();
		if (lx_word) begin
			lex_emit(PIECE_WORD_END, KIND_WORD, 8'h00);
			lx_word = 1'b0;
		end
	endfunction

	function automatic void lex_token(input logic [3:0] kind);
		lex_close_word();
		lex_emit(PIECE_TOKEN, kind, 8'h00);
	endfunction

	function automatic void lex_fail();
		lex_emit(PIECE_ERROR, KIND_WORD, 8'h00);
		lx_failed = 1'b1;
	endfunction

	// Judges one byte against its look-ahead; returns 1 when a pair eats it
	function automatic bit lex_judge(input logic [7:0] ch, input bit has_nx,
			input logic [7:0] nx);
		bit pair;
		pair = 1'b0;
		if (lx_comment && ch != CH_LF) return 1'b0;
		case (ch)
			CH_HASH: begin
				if (has_nx && word_char(nx)) begin
					lex_emit(PIECE_WORD_BYTE, KIND_WORD, ch);
					lx_word = 1'b1;
				end else begin
					lx_comment = 1'b1;
				end
			end
			CH_BSLASH: begin
				lx_cont = 1'b1;
				if (!(has_nx && nx == CH_LF)) lex_fail();
			end
			CH_LF: begin
				lex_token(lx_cont ? KIND_BACKSLASH : KIND_NEWLINE);
				lx_cont    = 1'b0;
				lx_comment = 1'b0;
				if (lx_line != 16'hFFFF) lx_line = lx_line + 16'd1;
			end
			CH_SPACE, CH_TAB: lex_close_word();
			CH_SEMI: lex_token(KIND_SEQ);
			CH_GT: lex_token(KIND_OUT);
			CH_LT: lex_token(KIND_IN);
			CH_LPAREN: lex_token(KIND_LB);
			CH_RPAREN: lex_token(KIND_RB);
			CH_PIPE: begin
				if (has_nx && nx == CH_PIPE) begin
					lex_token(KIND_OR);
					pair = 1'b1;
				end else begin
					lex_token(KIND_PIPE);
				end
			end
			CH_AMP: begin
				if (has_nx && nx == CH_AMP) begin
					lex_token(KIND_AND);
					pair = 1'b1;
				end else begin
					lex_fail();
				end
			end
			default: begin
				if (word_char(ch)) begin
					lex_emit(PIECE_WORD_BYTE, KIND_WORD, ch);
					lx_word = 1'b1;
				end else begin
					lex_fail();
				end
			end
		endcase
		return pair;
	endfunction

	// One accepted byte: judge the held one, hold or finish this one
	function automatic void lex_step(input logic [7:0] c, input logic last);
		int first;
		first = lexeme_q.size();
		if (!lx_failed) begin
			if (lx_held_v) begin
				if (lx_skip)
					lx_skip = 1'b0;
				else if (lex_judge(lx_held, 1'b1, c))
					lx_skip = 1'b1;
				lx_held_v = 1'b0;
			end
			if (!lx_failed) begin
				if (last) begin
					if (!lx_skip) void'(lex_judge(c, 1'b0, 8'h00));
					lx_skip = 1'b0;
					if (!lx_failed) lex_close_word();
				end else begin
					lx_held   = c;
					lx_held_v = 1'b1;
				end
			end
		end
		if (last) begin
			lex_emit(PIECE_END, KIND_WORD, 8'h00);
			lex_clear();
		end
		if (lexeme_q.size() > first) lexeme_q[lexeme_q.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	// Mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int add_bytes(input byte_q_t txt, input bit quiet);
		text_byte_t it;
		for (int i = 0; i < txt.size(); i++) begin
			it.ch    = txt[i];
			it.last  = (i == txt.size() - 1);
			it.quiet = quiet;
			it.gap   = (quiet || $urandom_range(0, 99) < 70) ? 0 : idle_len();
			text_q.push_back(it);
		end
		return txt.size();
	endfunction

	function automatic void add_str(input string s);
		byte_q_t txt;
		for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
		void'(add_bytes(txt, 1'b0));
	endfunction

	// A command text: mostly well formed, with some noise and broken pieces
	function automatic int add_random_text();
		byte_q_t txt;
		string   wset;
		string   ops;
		int      n;
		int      pick;
		int      len;
		bit      quiet;
		wset  = "09azAZ!%+,-./:@^_mq7K";
		ops   = "<>();|&";
		quiet = ($urandom_range(0, 99) < 15);
		n     = $urandom_range(1, 8);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				if ($urandom_range(0, 99) < 15) txt.push_back(CH_HASH);
				len = $urandom_range(1, 4);
				for (int j = 0; j < len; j++)
					txt.push_back(wset[$urandom_range(0, wset.len() - 1)]);
			end else if (pick < 50) begin
				txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			end else if (pick < 62) begin
				txt.push_back(ops[$urandom_range(0, ops.len() - 1)]);
			end else if (pick < 68) begin
				txt.push_back($urandom_range(0, 1) ? CH_PIPE : CH_AMP);
				txt.push_back(txt[txt.size() - 1]);
			end else if (pick < 78) begin
				txt.push_back(CH_LF);
			end else if (pick < 84) begin
				txt.push_back(CH_BSLASH);
				txt.push_back(CH_LF);
			end else if (pick < 90) begin
				// comment, closed by a newline most of the time
				txt.push_back(CH_HASH);
				txt.push_back(CH_SPACE);
				txt.push_back(wset[$urandom_range(0, wset.len() - 1)]);
				txt.push_back(8'($urandom_range(0, 99)));
				if ($urandom_range(0, 3) != 0) txt.push_back(CH_LF);
			end else if (pick < 95) begin
				txt.push_back(8'($urandom_range(0, 255)));
			end else begin
				txt.push_back($urandom_range(0, 1) ? CH_BSLASH : CH_AMP);
			end
		end
		return add_bytes(txt, quiet);
	endfunction

	initial begin
		byte_q_t txt;
		int      rand_items;
		lex_clear();
		// operators, word with leading hash, continuation, comment, pipe at end
		add_str("#Z|| b&&(c)<>;\\\n#\tz\n|");
		// lone ampersand at the end, comment at the end, stray backslash
		add_str("&");
		add_str("#\\");
		add_str("w\\x");
		// bad bytes inside an open word; later bytes ignored
		txt = '{8'h77, 8'hFF, 8'h00};
		void'(add_bytes(txt, 1'b0));
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) rand_items += add_random_text();

		wait (arst_n);
		while (text_q.size() > 0 || s_axis_tvalid || lexeme_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("shell_command_lexer test passed");
		else
			$display("shell_command_lexer test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: next item after its gap, valid held until accepted
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			drv_valid = s_axis_tvalid && !in_fired;
			if (!drv_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (text_q.size() > 0) begin
					drv_item = text_q.pop_front();
					s_axis_tdata <= drv_item.ch;
					s_axis_tlast <= drv_item.last;
					rx_calm      <= drv_item.quiet;
					drv_valid    = 1'b1;
					if (text_q.size() > 0) gap_left = text_q[0].gap;
				end
			end
			s_axis_tvalid <= drv_valid;
		end
	end

	// Receiver stalls
	always @(negedge clk) begin
		if (arst_n) begin
			rx_ready = 1'b1;
			if (stall_left > 0) begin
				stall_left--;
				rx_ready = 1'b0;
			end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
				stall_left = idle_len() - 1;
				rx_ready   = 1'b0;
			end
			m_axis_tready <= rx_ready;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check results, then predict from the accepted byte
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("shell_command_lexer test failed");
				$finish;
			end else begin
				in_fired = s_axis_tvalid && s_axis_tready;
				if (m_axis_tvalid && m_axis_tready) begin
					if (lexeme_q.size() == 0) begin
						$error("unexpected result: piece %0d kind %0d byte_out %0d",
							m_axis_tuser[2:0], m_axis_tuser[6:3], m_axis_tdata[7:0]);
						err_count++;
					end else begin
						want = lexeme_q.pop_front();
						if (m_axis_tuser[2:0] !== want.piece) begin
							$error("piece: expected %0d, actual %0d",
								want.piece, m_axis_tuser[2:0]);
							err_count++;
						end
						if (m_axis_tuser[6:3] !== want.kind) begin
							$error("kind: expected %0d, actual %0d",
								want.kind, m_axis_tuser[6:3]);
							err_count++;
						end
						if (m_axis_tdata[7:0] !== want.chr) begin
							$error("byte_out: expected %0d, actual %0d",
								want.chr, m_axis_tdata[7:0]);
							err_count++;
						end
						if (m_axis_tdata[23:8] !== want.line) begin
							$error("line_number: expected %0d, actual %0d",
								want.line, m_axis_tdata[23:8]);
							err_count++;
						end
						if (m_axis_tlast !== want.last) begin
							$error("last_of_run: expected %0d, actual %0d",
								want.last, m_axis_tlast);
							err_count++;
						end
					end
				end
				if (in_fired) lex_step(s_axis_tdata, s_axis_tlast);
			end
		end
	end

endmodule
